// ===== design/sk5_pkg.sv =====
`timescale 1ns / 1ps

package sk5_pkg;

  // Protocol bytes.
  localparam logic [7:0] SOCKS_VER      = 8'h05;
  localparam logic [7:0] CMD_CONNECT    = 8'h01;
  localparam logic [7:0] ATYP_IPV4      = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
  localparam logic [7:0] ATYP_IPV6      = 8'h04;
  localparam logic [7:0] METHOD_NOAUTH  = 8'h00;
  localparam logic [7:0] METHOD_NONE    = 8'hff;
  localparam logic [7:0] REP_SUCCEEDED  = 8'h00;
  localparam logic [7:0] REP_FAILURE    = 8'h01;
  localparam logic [7:0] REP_BAD_CMD    = 8'h07;
  localparam logic [7:0] REP_BAD_ATYP   = 8'h08;
  localparam logic [7:0] REP_RSV        = 8'h00;
  localparam logic [7:0] REP_BND_ATYP   = 8'h01;
  localparam logic [7:0] REP_PAD        = 8'h00;

  localparam logic [7:0] IPV4_LEN = 8'd4;
  localparam logic [7:0] IPV6_LEN = 8'd16;

  // Request error codes; the last one found wins.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_VERSION  = 2'd1;
  localparam logic [1:0] ERR_COMMAND  = 2'd2;
  localparam logic [1:0] ERR_ADDRTYPE = 2'd3;

  // Destination address kinds.
  localparam logic [1:0] AK_IPV4   = 2'd0;
  localparam logic [1:0] AK_DOMAIN = 2'd1;
  localparam logic [1:0] AK_IPV6   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_ADDR  = 2'd1;
  localparam logic [1:0] KIND_GRANT = 2'd2;
  localparam logic [1:0] KIND_CLOSE = 2'd3;

  // Position of the final result within a request reply burst.
  localparam logic [3:0] REQ_LAST_IDX = 4'd10;

  typedef enum logic [3:0] {
    PH_GVER    = 4'd0,
    PH_NMETH   = 4'd1,
    PH_METHODS = 4'd2,
    PH_RVER    = 4'd3,
    PH_RCMD    = 4'd4,
    PH_RSV     = 4'd5,
    PH_ATYP    = 4'd6,
    PH_DLEN    = 4'd7,
    PH_ADDR    = 4'd8,
    PH_PORTH   = 4'd9,
    PH_PORTL   = 4'd10,
    PH_GRANTED = 4'd11,
    PH_CLOSED  = 4'd12
  } phase_t;

  typedef enum logic [1:0] {
    BURST_ADDR  = 2'd0,
    BURST_GREET = 2'd1,
    BURST_REQ   = 2'd2
  } burst_t;

  // One parsed byte's worth of results, expanded later by the emitter.
  typedef struct packed {
    burst_t      kind;
    logic        ok;
    logic [7:0]  data;
    logic [7:0]  rep;
    logic [1:0]  addr_type;
    logic [15:0] port;
  } desc_t;

  function automatic logic [7:0] rep_of(input logic [1:0] err);
    logic [7:0] r;
    unique case (err)
      ERR_NONE:    r = REP_SUCCEEDED;
      ERR_VERSION: r = REP_FAILURE;
      ERR_COMMAND: r = REP_BAD_CMD;
      default:     r = REP_BAD_ATYP;
    endcase
    return r;
  endfunction

endpackage

// ===== design/sk5_in_if.sv =====
`timescale 1ns / 1ps

interface sk5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       session_start;

  modport source(output valid, output rx_byte, output session_start, input ready);
  modport sink(input valid, input rx_byte, input session_start, output ready);
endinterface

// ===== design/sk5_out_if.sv =====
`timescale 1ns / 1ps

interface sk5_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [1:0]  addr_type;
  logic [15:0] dest_port;
  logic        last;

  modport source(output valid, output out_kind, output out_byte, output addr_type,
                 output dest_port, output last, input ready);
  modport sink(input valid, input out_kind, input out_byte, input addr_type,
               input dest_port, input last, output ready);
endinterface

// ===== design/sk5_parser.sv =====
`timescale 1ns / 1ps

module sk5_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     rx_byte,
  input  logic           session_start,
  output logic           push,
  output sk5_pkg::desc_t desc
);

  sk5_pkg::phase_t phase_r, phase_nxt, ph_e;
  logic [7:0] byte_count_r, byte_count_nxt, cnt_e;
  logic [7:0] method_count_r, method_count_nxt, mcnt_e;
  logic       noauth_r, noauth_nxt, noauth_e;
  logic [1:0] error_r, error_nxt, err_e;
  logic [1:0] akind_r, akind_nxt, akind_e;
  logic [7:0] alen_r, alen_nxt, alen_e;
  logic [7:0] phigh_r, phigh_nxt, phigh_e;

  logic [7:0] mcnt_dec;
  logic [7:0] cnt_inc;
  logic       noauth_upd;
  logic       greet_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= sk5_pkg::PH_GVER;
      byte_count_r   <= '0;
      method_count_r <= '0;
      noauth_r       <= 1'b0;
      error_r        <= sk5_pkg::ERR_NONE;
      akind_r        <= sk5_pkg::AK_IPV4;
      alen_r         <= '0;
      phigh_r        <= '0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      method_count_r <= method_count_nxt;
      noauth_r       <= noauth_nxt;
      error_r        <= error_nxt;
      akind_r        <= akind_nxt;
      alen_r         <= alen_nxt;
      phigh_r        <= phigh_nxt;
    end
  end

  always_comb begin
    // A session start restarts from the reset state before this byte is parsed.
    ph_e     = session_start ? sk5_pkg::PH_GVER : phase_r;
    cnt_e    = session_start ? 8'd0 : byte_count_r;
    mcnt_e   = session_start ? 8'd0 : method_count_r;
    noauth_e = session_start ? 1'b0 : noauth_r;
    err_e    = session_start ? sk5_pkg::ERR_NONE : error_r;
    akind_e  = session_start ? sk5_pkg::AK_IPV4 : akind_r;
    alen_e   = session_start ? 8'd0 : alen_r;
    phigh_e  = session_start ? 8'd0 : phigh_r;

    phase_nxt        = ph_e;
    byte_count_nxt   = cnt_e;
    method_count_nxt = mcnt_e;
    noauth_nxt       = noauth_e;
    error_nxt        = err_e;
    akind_nxt        = akind_e;
    alen_nxt         = alen_e;
    phigh_nxt        = phigh_e;

    mcnt_dec   = mcnt_e - 8'd1;
    cnt_inc    = cnt_e + 8'd1;
    noauth_upd = noauth_e | (rx_byte == sk5_pkg::METHOD_NOAUTH);
    greet_ok   = 1'b0;

    push           = 1'b0;
    desc.kind      = sk5_pkg::BURST_ADDR;
    desc.ok        = 1'b0;
    desc.data      = rx_byte;
    desc.rep       = sk5_pkg::rep_of(err_e);
    desc.addr_type = akind_e;
    desc.port      = 16'd0;

    unique case (ph_e)
      sk5_pkg::PH_GVER: begin
        error_nxt  = (rx_byte != sk5_pkg::SOCKS_VER) ? sk5_pkg::ERR_VERSION
                                                     : sk5_pkg::ERR_NONE;
        noauth_nxt = 1'b0;
        phase_nxt  = sk5_pkg::PH_NMETH;
      end
      sk5_pkg::PH_NMETH: begin
        method_count_nxt = rx_byte;
        if (rx_byte == 8'd0) begin
          greet_ok  = (err_e == sk5_pkg::ERR_NONE) && noauth_e;
          push      = 1'b1;
          desc.kind = sk5_pkg::BURST_GREET;
          desc.ok   = greet_ok;
          phase_nxt = greet_ok ? sk5_pkg::PH_RVER : sk5_pkg::PH_CLOSED;
        end else begin
          phase_nxt = sk5_pkg::PH_METHODS;
        end
      end
      sk5_pkg::PH_METHODS: begin
        noauth_nxt       = noauth_upd;
        method_count_nxt = mcnt_dec;
        if (mcnt_dec == 8'd0) begin
          greet_ok  = (err_e == sk5_pkg::ERR_NONE) && noauth_upd;
          push      = 1'b1;
          desc.kind = sk5_pkg::BURST_GREET;
          desc.ok   = greet_ok;
          phase_nxt = greet_ok ? sk5_pkg::PH_RVER : sk5_pkg::PH_CLOSED;
        end
      end
      sk5_pkg::PH_RVER: begin
        error_nxt = (rx_byte != sk5_pkg::SOCKS_VER) ? sk5_pkg::ERR_VERSION
                                                    : sk5_pkg::ERR_NONE;
        phase_nxt = sk5_pkg::PH_RCMD;
      end
      sk5_pkg::PH_RCMD: begin
        if (rx_byte != sk5_pkg::CMD_CONNECT) begin
          error_nxt = sk5_pkg::ERR_COMMAND;
        end
        phase_nxt = sk5_pkg::PH_RSV;
      end
      sk5_pkg::PH_RSV: begin
        phase_nxt = sk5_pkg::PH_ATYP;
      end
      sk5_pkg::PH_ATYP: begin
        byte_count_nxt = 8'd0;
        priority if (rx_byte == sk5_pkg::ATYP_IPV4) begin
          akind_nxt = sk5_pkg::AK_IPV4;
          alen_nxt  = sk5_pkg::IPV4_LEN;
          phase_nxt = sk5_pkg::PH_ADDR;
        end else if (rx_byte == sk5_pkg::ATYP_DOMAIN) begin
          akind_nxt = sk5_pkg::AK_DOMAIN;
          phase_nxt = sk5_pkg::PH_DLEN;
        end else if (rx_byte == sk5_pkg::ATYP_IPV6) begin
          akind_nxt = sk5_pkg::AK_IPV6;
          alen_nxt  = sk5_pkg::IPV6_LEN;
          phase_nxt = sk5_pkg::PH_ADDR;
        end else begin
          // Unknown address type ends the request right away.
          akind_nxt      = sk5_pkg::AK_IPV4;
          error_nxt      = sk5_pkg::ERR_ADDRTYPE;
          push           = 1'b1;
          desc.kind      = sk5_pkg::BURST_REQ;
          desc.ok        = 1'b0;
          desc.rep       = sk5_pkg::REP_BAD_ATYP;
          desc.addr_type = sk5_pkg::AK_IPV4;
          phase_nxt      = sk5_pkg::PH_CLOSED;
        end
      end
      sk5_pkg::PH_DLEN: begin
        alen_nxt  = rx_byte;
        phase_nxt = (rx_byte == 8'd0) ? sk5_pkg::PH_PORTH : sk5_pkg::PH_ADDR;
      end
      sk5_pkg::PH_ADDR: begin
        // Address bytes of a failed request are swallowed.
        push           = (err_e == sk5_pkg::ERR_NONE);
        desc.kind      = sk5_pkg::BURST_ADDR;
        byte_count_nxt = cnt_inc;
        if (cnt_inc >= alen_e) begin
          phase_nxt = sk5_pkg::PH_PORTH;
        end
      end
      sk5_pkg::PH_PORTH: begin
        phigh_nxt = rx_byte;
        phase_nxt = sk5_pkg::PH_PORTL;
      end
      sk5_pkg::PH_PORTL: begin
        push      = 1'b1;
        desc.kind = sk5_pkg::BURST_REQ;
        desc.ok   = (err_e == sk5_pkg::ERR_NONE);
        desc.port = {phigh_e, rx_byte};
        phase_nxt = (err_e == sk5_pkg::ERR_NONE) ? sk5_pkg::PH_GRANTED
                                                 : sk5_pkg::PH_CLOSED;
      end
      default: begin
        // Granted, closed and unused codes ignore the client until a restart.
      end
    endcase
  end

endmodule

// ===== design/sk5_desc_fifo.sv =====
`timescale 1ns / 1ps

module sk5_desc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sk5_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output sk5_pkg::desc_t head_desc
);

  sk5_pkg::desc_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           do_push;
  logic           do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_desc  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ===== design/sk5_emitter.sv =====
`timescale 1ns / 1ps

module sk5_emitter (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  sk5_pkg::desc_t head_desc,
  output logic           pop,
  sk5_out_if.source      out_ch
);

  logic [3:0] idx_r, idx_nxt;
  logic       xfer;
  logic       is_last;

  assign out_ch.valid = head_valid;
  assign xfer         = head_valid && out_ch.ready;
  assign pop          = xfer && is_last;
  assign out_ch.last  = is_last;

  always_comb begin
    out_ch.out_kind  = sk5_pkg::KIND_REPLY;
    out_ch.out_byte  = sk5_pkg::REP_PAD;
    out_ch.addr_type = sk5_pkg::AK_IPV4;
    out_ch.dest_port = 16'd0;
    is_last          = 1'b0;

    unique case (head_desc.kind)
      sk5_pkg::BURST_ADDR: begin
        out_ch.out_kind  = sk5_pkg::KIND_ADDR;
        out_ch.out_byte  = head_desc.data;
        out_ch.addr_type = head_desc.addr_type;
        is_last          = 1'b1;
      end
      sk5_pkg::BURST_GREET: begin
        // Good greeting: 05 00. Bad greeting: 05 FF and then closed.
        priority if (idx_r == 4'd0) begin
          out_ch.out_byte = sk5_pkg::SOCKS_VER;
        end else if (idx_r == 4'd1) begin
          out_ch.out_byte = head_desc.ok ? sk5_pkg::METHOD_NOAUTH : sk5_pkg::METHOD_NONE;
          is_last         = head_desc.ok;
        end else begin
          out_ch.out_kind = sk5_pkg::KIND_CLOSE;
          out_ch.out_byte = 8'd0;
          is_last         = 1'b1;
        end
      end
      sk5_pkg::BURST_REQ: begin
        priority if (idx_r == 4'd0) begin
          out_ch.out_byte = sk5_pkg::SOCKS_VER;
        end else if (idx_r == 4'd1) begin
          out_ch.out_byte = head_desc.rep;
        end else if (idx_r == 4'd2) begin
          out_ch.out_byte = sk5_pkg::REP_RSV;
        end else if (idx_r == 4'd3) begin
          out_ch.out_byte = sk5_pkg::REP_BND_ATYP;
        end else if (idx_r >= sk5_pkg::REQ_LAST_IDX) begin
          out_ch.out_byte = 8'd0;
          is_last         = 1'b1;
          if (head_desc.ok) begin
            out_ch.out_kind  = sk5_pkg::KIND_GRANT;
            out_ch.addr_type = head_desc.addr_type;
            out_ch.dest_port = head_desc.port;
          end else begin
            out_ch.out_kind = sk5_pkg::KIND_CLOSE;
          end
        end else begin
          out_ch.out_byte = sk5_pkg::REP_PAD;
        end
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (xfer) begin
      idx_nxt = is_last ? 4'd0 : idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 4'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// ===== design/socks5_server_handshake_top.sv =====
`timescale 1ns / 1ps

// SOCKS5 server handshake: takes the client's bytes one per transfer on in_ch and
// returns the server's reply bytes, the passed-through destination address bytes
// and a final granted or closed marker on out_ch. The parser takes one byte per
// cycle while in_ch is ready and files the results of each byte that has any as
// one entry in a two-deep queue. The emitter then sends that entry's results one
// per cycle while out_ch is ready. With the queue empty, the first result appears
// in the cycle after the byte's transfer. An address byte yields one result, a
// greeting reply two or three and a request reply eleven. in_ch is ready while the
// queue holds fewer than two entries, so bytes flow at one per cycle until two
// entries are waiting. From then on every byte waits, whether or not it causes a
// result, until the emitter has sent the last result of the head entry.
module socks5_server_handshake_top (
  input  logic      clk,
  input  logic      rst_n,
  sk5_in_if.sink    in_ch,
  sk5_out_if.source out_ch
);

  logic           accept;
  logic           push;
  logic           full;
  logic           pop;
  logic           head_valid;
  sk5_pkg::desc_t push_desc;
  sk5_pkg::desc_t head_desc;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && in_ch.ready;

  sk5_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .rx_byte       (in_ch.rx_byte),
    .session_start (in_ch.session_start),
    .push          (push),
    .desc          (push_desc)
  );

  sk5_desc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push && accept),
    .push_desc  (push_desc),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  sk5_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
